[hdl/sliding_window_regression_slope_defines.svh]
// assertion macros for the checker file
`ifndef SLIDING_WINDOW_REGRESSION_SLOPE_DEFINES_SVH
`define SLIDING_WINDOW_REGRESSION_SLOPE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SWRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SWRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[hdl/swrs_pkg.sv]
package swrs_pkg;

	localparam int COORD_W = 24;
	localparam int SLOPE_W = 48;
	localparam int CFG_W = 6;
	localparam int WINDOW_RESET = 5;

	localparam logic [SLOPE_W-1:0] SLOPE_POS_LIMIT = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic [SLOPE_W-1:0] SLOPE_NEG_LIMIT = {1'b1, {(SLOPE_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SLOPE_W-1:0] slope_t;

	// divider request and response
	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic saturated;
	} div_rsp_t;

endpackage

[hdl/swrs_if.sv]
interface swrs_in_if;
	import swrs_pkg::*;

	logic valid;
	logic ready;
	coord_t x_value;
	coord_t y_value;
	logic set_start;

	modport source (output valid, output x_value, output y_value, output set_start,
		input ready);
	modport sink (input valid, input x_value, input y_value, input set_start,
		output ready);
endinterface

interface swrs_out_if;
	import swrs_pkg::*;

	logic valid;
	logic ready;
	slope_t slope;
	coord_t center_x;
	logic degenerate;
	logic saturated;

	modport source (output valid, output slope, output center_x, output degenerate,
		output saturated, input ready);
	modport sink (input valid, input slope, input center_x, input degenerate,
		input saturated, output ready);
endinterface

[hdl/swrs_ring.sv]
module swrs_ring #(
	parameter int DEPTH = 33,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input swrs_pkg::coord_t wr_x,
	input swrs_pkg::coord_t wr_y,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output swrs_pkg::coord_t rd_x,
	output swrs_pkg::coord_t rd_y
);
	import swrs_pkg::*;

	coord_t mem_x [DEPTH];
	coord_t mem_y [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
		end
		if (rd_en) begin
			rd_x <= mem_x[rd_addr];
			rd_y <= mem_y[rd_addr];
		end
	end

endmodule

[hdl/swrs_div.sv]
module swrs_div #(
	parameter int P_W = 60,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input swrs_pkg::div_req_t req,
	input logic [P_W-1:0] mag,
	input logic [P_W-1:0] den,
	output swrs_pkg::div_rsp_t rsp,
	output logic [swrs_pkg::SLOPE_W-1:0] slope
);
	import swrs_pkg::*;

	localparam int N_W = P_W + FRAC_BITS;
	localparam int CW = $clog2(SLOPE_W + 1);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [P_W-1:0] rem_q;
	logic [P_W-1:0] den_q;
	logic [SLOPE_W-1:0] num_lo_q;
	logic [SLOPE_W-1:0] quo_q;
	logic big_q;
	logic neg_q;

	logic [N_W-1:0] num_full;
	logic [P_W-1:0] num_top;
	logic [P_W:0] trial;
	logic fits;
	logic over;
	logic [SLOPE_W-1:0] qmag;

	// numerator is the magnitude with the fraction bits appended
	assign num_full = N_W'(mag) << FRAC_BITS;
	// part above the quotient field; at or above the divisor means quotient >= 2^48
	assign num_top = P_W'(num_full >> SLOPE_W);

	assign trial = {rem_q, num_lo_q[SLOPE_W-1]};
	assign fits = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(SLOPE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_top;
			den_q <= den;
			num_lo_q <= num_full[SLOPE_W-1:0];
			quo_q <= '0;
			big_q <= (num_top >= den);
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? P_W'(trial - {1'b0, den_q}) : P_W'(trial);
			num_lo_q <= num_lo_q << 1;
			quo_q <= {quo_q[SLOPE_W-2:0], fits};
		end
	end

	// clamp to the signed 48-bit range
	always_comb begin
		if (neg_q) begin
			over = big_q | (quo_q[SLOPE_W-1] & (|quo_q[SLOPE_W-2:0]));
			qmag = over ? SLOPE_NEG_LIMIT : quo_q;
			slope = SLOPE_W'(0) - qmag;
		end else begin
			over = big_q | quo_q[SLOPE_W-1];
			qmag = quo_q;
			slope = over ? SLOPE_POS_LIMIT : qmag;
		end
	end

	assign rsp.done = done_q;
	assign rsp.saturated = over;

endmodule

[hdl/sliding_window_regression_slope.sv]
// channel   dir  handshake            payload
// sample    in   valid / ready        x_value, y_value, set_start
// result    out  valid / ready        slope, center_x, degenerate, saturated
// cfg       in   cfg_wr_en (no wait)  cfg_wr_data = window_points
//
// one item at a time: ready is high only while the sequencer is idle
// an item that leaves the window short ends once the sums update, a degenerate result
// skips the divider, and a full slope runs the one-bit-per-cycle restoring divider
// a finished result sits in the output register, so the next item is taken
// while the result still waits for ready
// arst_n clears the sums, fill count, write pointer and sets a five-point window;
// a config write clears the window the same way
module sliding_window_regression_slope #(
	parameter int MAX_HALF_WIDTH = 16,
	parameter int SLOPE_FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	swrs_in_if.sink sample,
	swrs_out_if.source result,
	input logic cfg_wr_en,
	input logic [swrs_pkg::CFG_W-1:0] cfg_wr_data
);
	import swrs_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int PTR_W = AW + 1;
	// count width, holds DEPTH itself
	localparam int NW = $clog2(DEPTH + 1);
	localparam int SX_W = COORD_W + NW;
	localparam int SXX_W = 2 * COORD_W + NW;
	localparam int P_W = 2 * SX_W;
	localparam int RST_LEN = (WINDOW_RESET > DEPTH) ? DEPTH : WINDOW_RESET;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_OLD,
		S_WR,
		S_RD_MID,
		S_MUL,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	// steps of the shared multiplier pass
	typedef enum logic [2:0] {
		ST_XX,
		ST_XY,
		ST_OXX,
		ST_OXY,
		ST_SUMS,
		ST_SQ,
		ST_SXX,
		ST_SXY
	} step_t;

	state_t state_q;
	step_t step_q;

	logic [NW-1:0] len_q;
	logic [NW-1:0] fill_q;
	logic [AW-1:0] wp_q;
	logic full_q;
	logic signed [SX_W-1:0] sum_x_q;
	logic signed [SX_W-1:0] sum_y_q;
	logic signed [SXX_W-1:0] sum_xx_q;
	logic signed [SXX_W-1:0] sum_xy_q;
	logic out_valid_q;

	// payload registers
	coord_t x_q;
	coord_t y_q;
	coord_t xo_q;
	coord_t yo_q;
	coord_t center_q;
	logic signed [P_W-1:0] prod_q;
	logic signed [P_W-1:0] sxx_q;
	logic signed [P_W-1:0] sxy_q;
	slope_t res_slope_q;
	logic res_degen_q;
	logic res_sat_q;
	slope_t out_slope_q;
	coord_t out_center_q;
	logic out_degen_q;
	logic out_sat_q;

	logic accept;
	logic load_out;
	logic degen;
	logic [CFG_W-1:0] cfg_odd;
	logic [NW-1:0] cfg_len;
	logic [PTR_W-1:0] old_sum;
	logic [PTR_W-1:0] mid_sum;
	logic [AW-1:0] old_addr;
	logic [AW-1:0] mid_addr;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic wr_en;
	coord_t rd_x;
	coord_t rd_y;
	logic signed [SX_W-1:0] mul_a;
	logic signed [SX_W-1:0] mul_b;
	logic signed [P_W-1:0] nsum;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [P_W-1:0] div_mag;
	logic [SLOPE_W-1:0] div_slope;

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// window length: setting forced odd, clamped to the ring depth
	assign cfg_odd = cfg_wr_data | CFG_W'(1);
	assign cfg_len = (int'(cfg_odd) > DEPTH) ? NW'(DEPTH) : NW'(cfg_odd);

	// oldest sample sits len back from the write pointer, the middle one len/2 back
	assign old_sum = PTR_W'(wp_q) + PTR_W'(DEPTH) - PTR_W'(len_q);
	assign mid_sum = PTR_W'(wp_q) + PTR_W'(DEPTH) - PTR_W'(len_q >> 1);
	assign old_addr = AW'((old_sum >= PTR_W'(DEPTH)) ? old_sum - PTR_W'(DEPTH) : old_sum);
	assign mid_addr = AW'((mid_sum >= PTR_W'(DEPTH)) ? mid_sum - PTR_W'(DEPTH) : mid_sum);

	// old entry read before the write, middle entry after it, so a one-point
	// window sees the new sample as its center
	assign rd_en = (state_q == S_RD_OLD) || (state_q == S_RD_MID);
	assign rd_addr = (state_q == S_RD_OLD) ? old_addr : mid_addr;
	assign wr_en = (state_q == S_WR);

	swrs_ring #(
		.DEPTH(DEPTH)
	) u_ring (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wp_q),
		.wr_x(x_q),
		.wr_y(y_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_x(rd_x),
		.rd_y(rd_y)
	);

	// operand select for the shared signed multiplier
	always_comb begin
		unique case (step_q)
			ST_XX: begin
				mul_a = SX_W'(x_q);
				mul_b = SX_W'(x_q);
			end
			ST_XY: begin
				mul_a = SX_W'(x_q);
				mul_b = SX_W'(y_q);
			end
			ST_OXX: begin
				mul_a = SX_W'(xo_q);
				mul_b = SX_W'(xo_q);
			end
			ST_OXY: begin
				mul_a = SX_W'(xo_q);
				mul_b = SX_W'(yo_q);
			end
			ST_SQ: begin
				mul_a = sum_x_q;
				mul_b = sum_x_q;
			end
			ST_SXX: begin
				mul_a = sum_x_q;
				mul_b = sum_y_q;
			end
			default: begin
				mul_a = sum_x_q;
				mul_b = sum_y_q;
			end
		endcase
	end

	// narrow n * sum product, shared between the Sxx and Sxy steps
	assign nsum = P_W'($signed({1'b0, len_q}))
		* P_W'((step_q == ST_SXX) ? sum_xx_q : sum_xy_q);

	// zero or negative x spread gives no division
	assign degen = sxx_q[P_W-1] || (sxx_q == '0);

	assign div_req.start = (state_q == S_CHECK) && !degen;
	assign div_req.neg = sxy_q[P_W-1];
	assign div_mag = sxy_q[P_W-1] ? P_W'(0) - sxy_q : sxy_q;

	swrs_div #(
		.P_W(P_W),
		.FRAC_BITS(SLOPE_FRACTION_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.mag(div_mag),
		.den(sxx_q),
		.rsp(div_rsp),
		.slope(div_slope)
	);

	// sequencer, window bookkeeping and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= ST_XX;
			len_q <= NW'(RST_LEN);
			fill_q <= '0;
			wp_q <= '0;
			full_q <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_xx_q <= '0;
			sum_xy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD_OLD;
						if (sample.set_start) begin
							fill_q <= '0;
							wp_q <= '0;
							sum_x_q <= '0;
							sum_y_q <= '0;
							sum_xx_q <= '0;
							sum_xy_q <= '0;
						end
					end
				end
				S_RD_OLD: begin
					// full before this item: the oldest point drops out
					full_q <= (fill_q == len_q);
					if (fill_q != len_q) begin
						fill_q <= fill_q + NW'(1);
					end
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= S_RD_MID;
				end
				S_RD_MID: begin
					wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
					step_q <= ST_XX;
					state_q <= S_MUL;
				end
				S_MUL: begin
					unique case (step_q)
						ST_XX: begin
							step_q <= ST_XY;
						end
						ST_XY: begin
							sum_xx_q <= sum_xx_q + SXX_W'(prod_q);
							step_q <= ST_OXX;
						end
						ST_OXX: begin
							sum_xy_q <= sum_xy_q + SXX_W'(prod_q);
							step_q <= ST_OXY;
						end
						ST_OXY: begin
							if (full_q) begin
								sum_xx_q <= sum_xx_q - SXX_W'(prod_q);
							end
							step_q <= ST_SUMS;
						end
						ST_SUMS: begin
							if (full_q) begin
								sum_xy_q <= sum_xy_q - SXX_W'(prod_q);
							end
							sum_x_q <= sum_x_q + SX_W'(x_q)
								- (full_q ? SX_W'(xo_q) : SX_W'(0));
							sum_y_q <= sum_y_q + SX_W'(y_q)
								- (full_q ? SX_W'(yo_q) : SX_W'(0));
							// window still filling: no result for this item
							if (fill_q != len_q) begin
								state_q <= S_IDLE;
							end else begin
								step_q <= ST_SQ;
							end
						end
						ST_SQ: begin
							step_q <= ST_SXX;
						end
						ST_SXX: begin
							step_q <= ST_SXY;
						end
						ST_SXY: begin
							step_q <= ST_XX;
							state_q <= S_CHECK;
						end
						default: begin
							step_q <= ST_XX;
						end
					endcase
				end
				S_CHECK: begin
					state_q <= degen ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a config write must only come while idle, unenforced; it restarts the window
			if (cfg_wr_en) begin
				len_q <= cfg_len;
				fill_q <= '0;
				wp_q <= '0;
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_xx_q <= '0;
				sum_xy_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample.x_value;
			y_q <= sample.y_value;
		end
		if (state_q == S_WR) begin
			xo_q <= rd_x;
			yo_q <= rd_y;
		end
		if ((state_q == S_MUL) && (step_q == ST_XX)) begin
			center_q <= rd_x;
		end
		// one product per cycle, consumed on the next step
		prod_q <= P_W'(mul_a) * P_W'(mul_b);
		if ((state_q == S_MUL) && (step_q == ST_SXX)) begin
			sxx_q <= nsum - prod_q;
		end
		if ((state_q == S_MUL) && (step_q == ST_SXY)) begin
			sxy_q <= nsum - prod_q;
		end
		if ((state_q == S_CHECK) && degen) begin
			res_slope_q <= '0;
			res_degen_q <= 1'b1;
			res_sat_q <= 1'b0;
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			res_slope_q <= div_slope;
			res_degen_q <= 1'b0;
			res_sat_q <= div_rsp.saturated;
		end
		if (load_out) begin
			out_slope_q <= res_slope_q;
			out_center_q <= center_q;
			out_degen_q <= res_degen_q;
			out_sat_q <= res_sat_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.slope = out_slope_q;
	assign result.center_x = out_center_q;
	assign result.degenerate = out_degen_q;
	assign result.saturated = out_sat_q;

endmodule

[hdl/swrs_checker.sv]
`include "sliding_window_regression_slope_defines.svh"

module swrs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input swrs_pkg::slope_t slope,
	input logic degenerate,
	input logic saturated
);
	import swrs_pkg::*;

	// the sequencer leaves idle as soon as it takes an item
	`SWRS_ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_valid && in_ready, !in_ready, "ready stayed high after an item")

	// no x spread gives a zero, unclamped slope
	`SWRS_ASSERT_NOW(a_degen_zero, clk, arst_n, out_valid && degenerate, (slope == '0) && !saturated, "degenerate result with nonzero slope")

	// a clamped slope sits on one of the two range limits
	`SWRS_ASSERT_NOW(a_sat_limit, clk, arst_n, out_valid && saturated, (slope == SLOPE_POS_LIMIT) || (slope == SLOPE_NEG_LIMIT), "saturated slope off the range limits")

	// a stalled result holds
	`SWRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(slope), "stalled result changed")

endmodule

bind sliding_window_regression_slope swrs_checker u_swrs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.slope(result.slope),
	.degenerate(result.degenerate),
	.saturated(result.saturated)
);
